/* hdl/madd_pkg.sv */
`timescale 1ns / 1ps

package madd_pkg;

  localparam int SAMPLE_W           = 10;
  localparam int COUNT_W            = 32;
  localparam int RING_DEPTH_DEFAULT = 20;
  localparam int WINDOW_LEN_DEFAULT = 10;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(14);

endpackage

/* hdl/moving_average_drop_detector_top.sv */
`timescale 1ns / 1ps

// Moving-average drop detector. Each sample item yields one result item: window_full once
// RING_DEPTH samples have been seen, drop_found when the average of the oldest WINDOW_LEN
// samples minus the average of the window starting at the last of those exceeds
// drop_threshold (cfg_write/cfg_data), and the 32-bit running sample number. A new item is
// taken every cycle unless sample_stall holds it back; an accepted sample passes through the
// input register, the running window-sum update into stage 2, and the result register
// behind the reciprocal multiply that forms the averages. No clearing pass is
// needed after reset.
module moving_average_drop_detector_top #(
  parameter int RING_DEPTH = madd_pkg::RING_DEPTH_DEFAULT,
  parameter int WINDOW_LEN = madd_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [madd_pkg::SAMPLE_W-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          drop_found,
  output logic                          window_full,
  output logic [madd_pkg::COUNT_W-1:0]  sample_number,
  input  logic                          cfg_write,
  input  logic [madd_pkg::SAMPLE_W-1:0] cfg_data
);
  import madd_pkg::*;

  localparam int FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int SUM_W     = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((longint'(1) << DIV_SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [SAMPLE_W-1:0] drop_threshold;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s2_valid;
  logic [SAMPLE_W-1:0] sample_ring [RING_DEPTH];
  logic [FILL_W-1:0]   fill_level;
  logic [SUM_W-1:0]    old_window_sum;
  logic [SUM_W-1:0]    new_window_sum;
  logic [SUM_W-1:0]    old_window_sum_next;
  logic [SUM_W-1:0]    new_window_sum_next;
  logic [COUNT_W-1:0]  sample_count;

  logic                en1, en2, en3, advance;
  logic                ring_full;
  logic [PROD_W-1:0]   old_prod, new_prod;
  logic [SAMPLE_W-1:0] old_avg, new_avg;
  logic                over_threshold;

  assign en3          = !result_valid || !result_stall;
  assign en2          = !s2_valid || en3;
  assign en1          = !s1_valid || en2;
  assign sample_stall = !en1;
  assign advance      = s1_valid && en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      drop_threshold <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sample <= sample;
    end
  end

  // ring as a shift line, entry 0 newest
  always_ff @(posedge clk) begin
    if (advance) begin
      sample_ring[0] <= s1_sample;
      for (int i = 1; i < RING_DEPTH; i++) begin
        sample_ring[i] <= sample_ring[i-1];
      end
    end
  end

  madd_window_sum #(
    .RING_DEPTH (RING_DEPTH),
    .WINDOW_LEN (WINDOW_LEN),
    .FIRST_POS  (0),
    .FILL_W     (FILL_W),
    .SUM_W      (SUM_W)
  ) u_old_sum (
    .sample   (s1_sample),
    .taps     (sample_ring),
    .fill     (fill_level),
    .sum      (old_window_sum),
    .sum_next (old_window_sum_next)
  );

  madd_window_sum #(
    .RING_DEPTH (RING_DEPTH),
    .WINDOW_LEN (WINDOW_LEN),
    .FIRST_POS  (WINDOW_LEN - 1),
    .FILL_W     (FILL_W),
    .SUM_W      (SUM_W)
  ) u_new_sum (
    .sample   (s1_sample),
    .taps     (sample_ring),
    .fill     (fill_level),
    .sum      (new_window_sum),
    .sum_next (new_window_sum_next)
  );

  // window state always belongs to the item held in stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      fill_level     <= '0;
      old_window_sum <= '0;
      new_window_sum <= '0;
      sample_count   <= '0;
    end else begin
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (advance) begin
        if (fill_level != FILL_W'(RING_DEPTH)) begin
          fill_level <= fill_level + FILL_W'(1);
        end
        old_window_sum <= old_window_sum_next;
        new_window_sum <= new_window_sum_next;
        sample_count   <= sample_count + COUNT_W'(1);
      end
    end
  end

  // divide by window length through a reciprocal multiply
  assign ring_full      = (fill_level == FILL_W'(RING_DEPTH));
  assign old_prod       = PROD_W'(old_window_sum) * PROD_W'(RECIP);
  assign new_prod       = PROD_W'(new_window_sum) * PROD_W'(RECIP);
  assign old_avg        = old_prod[DIV_SHIFT +: SAMPLE_W];
  assign new_avg        = new_prod[DIV_SHIFT +: SAMPLE_W];
  assign over_threshold = {1'b0, old_avg} > ({1'b0, new_avg} + {1'b0, drop_threshold});

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en3) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      drop_found    <= ring_full && over_threshold;
      window_full   <= ring_full;
      sample_number <= sample_count;
    end
  end

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> sample_count == $past(sample_count) + COUNT_W'(1))
    else $error("sample count did not step with item");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(sample_count))
    else $error("sample count moved without item");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(RING_DEPTH))
    else $error("fill level beyond ring depth");

  a_full_stays: assert property (@(posedge clk) disable iff (rst)
    ring_full |=> ring_full)
    else $error("ring lost full state");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !en3 |=> s2_valid && $stable(old_window_sum) && $stable(new_window_sum))
    else $error("stage 2 item changed while stalled");

endmodule

/* hdl/madd_window_sum.sv */
`timescale 1ns / 1ps

module madd_window_sum #(
  parameter int RING_DEPTH = madd_pkg::RING_DEPTH_DEFAULT,
  parameter int WINDOW_LEN = madd_pkg::WINDOW_LEN_DEFAULT,
  parameter int FIRST_POS  = 0,
  parameter int FILL_W     = $clog2(RING_DEPTH + 1),
  parameter int SUM_W      = $clog2(WINDOW_LEN * ((1 << madd_pkg::SAMPLE_W) - 1) + 1)
) (
  input  logic [madd_pkg::SAMPLE_W-1:0] sample,
  input  logic [madd_pkg::SAMPLE_W-1:0] taps [RING_DEPTH],
  input  logic [FILL_W-1:0]             fill,
  input  logic [SUM_W-1:0]              sum,
  output logic [SUM_W-1:0]              sum_next
);
  import madd_pkg::*;

  localparam int LAST_POS   = FIRST_POS + WINDOW_LEN - 1;
  localparam int NUM_PIECES = LAST_POS / RING_DEPTH + 1;

  logic [SUM_W-1:0] add_term [NUM_PIECES];
  logic [SUM_W-1:0] sub_term [NUM_PIECES];
  logic [SUM_W-1:0] acc;

  // positions past the ring end fold back, so a window splits into linear spans;
  // each span gains the sample entering it and loses the one leaving it
  for (genvar k = 0; k < NUM_PIECES; k++) begin : g_piece
    localparam int BASE = k * RING_DEPTH;
    localparam int LO   = (FIRST_POS > BASE) ? FIRST_POS : BASE;
    localparam int HI   = (LAST_POS < BASE + RING_DEPTH - 1) ? LAST_POS
                                                             : BASE + RING_DEPTH - 1;
    localparam int J_LO = RING_DEPTH - 1 - (HI - BASE);
    localparam int J_HI = RING_DEPTH - 1 - (LO - BASE);

    if (LO > HI) begin : g_empty
      assign add_term[k] = '0;
      assign sub_term[k] = '0;
    end else begin : g_span
      if (J_LO == 0) begin : g_from_input
        assign add_term[k] = SUM_W'(sample);
      end else begin : g_from_ring
        assign add_term[k] = (fill >= FILL_W'(J_LO)) ? SUM_W'(taps[J_LO-1]) : '0;
      end
      assign sub_term[k] = (fill > FILL_W'(J_HI)) ? SUM_W'(taps[J_HI]) : '0;
    end
  end

  always_comb begin
    acc = sum;
    for (int k = 0; k < NUM_PIECES; k++) begin
      acc = acc + add_term[k] - sub_term[k];
    end
    sum_next = acc;
  end

endmodule

/* tb/tb_moving_average_drop_detector_top.sv */
`timescale 1ns / 1ps

module tb_moving_average_drop_detector_top;

  import madd_pkg::*;

  localparam int RING_DEPTH = RING_DEPTH_DEFAULT;
  localparam int WINDOW_LEN = WINDOW_LEN_DEFAULT;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic               drop_found;
    logic               window_full;
    logic [COUNT_W-1:0] sample_number;
  } drop_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                drop_found;
  logic                window_full;
  logic [COUNT_W-1:0]  sample_number;
  logic                cfg_write = 1'b0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  moving_average_drop_detector_top #(
    .RING_DEPTH(RING_DEPTH),
    .WINDOW_LEN(WINDOW_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drop_found   (drop_found),
    .window_full  (window_full),
    .sample_number(sample_number),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
  logic [4:0]          ring_head = '0;
  logic [4:0]          fill_level = '0;
  logic [COUNT_W-1:0]  sample_count = '0;
  logic [SAMPLE_W-1:0] drop_threshold = THRESHOLD_RESET;

  logic [SAMPLE_W-1:0] pending_samples [$];
  drop_result_t        expected_results [$];
  int                  error_count = 0;
  int                  src_gap = 0;
  int                  sink_gap = 0;
  bit                  quiet_src = 1'b0;
  bit                  quiet_sink = 1'b0;

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic predict_drop(input logic [SAMPLE_W-1:0] s);
    drop_result_t r;
    int old_sum;
    int new_sum;
    int old_avg;
    int new_avg;
    ring_copy[ring_head] = s;
    ring_head = (ring_head == RING_DEPTH - 1) ? '0 : ring_head + 5'd1;
    if (fill_level < RING_DEPTH) fill_level = fill_level + 5'd1;
    sample_count = sample_count + 1;
    r.window_full   = (fill_level == RING_DEPTH);
    r.drop_found    = 1'b0;
    r.sample_number = sample_count;
    if (r.window_full) begin
      // oldest sample sits at the head once the ring is full
      old_sum = 0;
      new_sum = 0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        old_sum += int'(ring_copy[(ring_head + k) % RING_DEPTH]);
        new_sum += int'(ring_copy[(ring_head + WINDOW_LEN - 1 + k) % RING_DEPTH]);
      end
      old_avg = old_sum / WINDOW_LEN;
      new_avg = new_sum / WINDOW_LEN;
      r.drop_found = (old_avg - new_avg) > int'(drop_threshold);
    end
    expected_results.push_back(r);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) predict_drop(sample);
      if (!sample_valid || !sample_stall) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
          src_gap = pick_gap(quiet_src);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    drop_result_t exp_r;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending: drop=%0b full=%0b number=%0d",
                   $time, drop_found, window_full, sample_number);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (drop_found !== exp_r.drop_found) begin
            $display("%0t: drop_found expected %0b actual %0b",
                     $time, exp_r.drop_found, drop_found);
            error_count++;
          end
          if (window_full !== exp_r.window_full) begin
            $display("%0t: window_full expected %0b actual %0b",
                     $time, exp_r.window_full, window_full);
            error_count++;
          end
          if (sample_number !== exp_r.sample_number) begin
            $display("%0t: sample_number expected %0d actual %0d",
                     $time, exp_r.sample_number, sample_number);
            error_count++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        result_stall <= 1'b1;
      end else begin
        sink_gap = pick_gap(quiet_sink);
        result_stall <= (sink_gap > 0);
        if (sink_gap > 0) sink_gap = sink_gap - 1;
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_threshold(input logic [SAMPLE_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    drop_threshold = v;
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  // step from one level to another with noise, or plain noise
  task automatic load_random(input int count);
    int n;
    int level_a;
    int level_b;
    int len_a;
    int len_b;
    int amp;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        level_a = $urandom_range(0, SAMPLE_MAX);
        level_b = $urandom_range(0, 3) == 0 ? $urandom_range(0, SAMPLE_MAX)
                                             : $urandom_range(0, level_a);
        len_a = $urandom_range(5, 25);
        len_b = $urandom_range(5, 25);
        amp   = $urandom_range(0, 20);
        for (int i = 0; i < len_a + len_b; i++) begin
          pending_samples.push_back(clamp_sample((i < len_a ? level_a : level_b)
                                                 + $urandom_range(0, 2 * amp) - amp));
        end
        n += len_a + len_b;
      end else begin
        len_a = $urandom_range(1, 15);
        for (int i = 0; i < len_a; i++)
          pending_samples.push_back(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        n += len_a;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full scale high then zero gives a drop once the ring fills
    for (int i = 0; i < 10; i++) pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
    for (int i = 0; i < 10; i++) pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
    pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
    pending_samples.push_back(SAMPLE_W'(10'h155));
    pending_samples.push_back(SAMPLE_W'(10'h2AA));
    wait_drained();

    write_threshold('0);
    quiet_src  = 1'b1;
    quiet_sink = 1'b1;
    load_random(200);
    wait_drained();

    write_threshold(SAMPLE_W'(SAMPLE_MAX));
    quiet_src  = 1'b0;
    quiet_sink = 1'b0;
    load_random(200);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_threshold(p == 4 ? SAMPLE_W'(1) : SAMPLE_W'($urandom_range(0, 200)));
      quiet_src  = ($urandom_range(0, 2) == 0);
      quiet_sink = ($urandom_range(0, 2) == 0);
      load_random(100);
      if (p == 2) wait_drained();
      load_random(100);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_moving_average_drop_detector_top OK");
    end else begin
      $display("tb_moving_average_drop_detector_top NOT OK");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("tb_moving_average_drop_detector_top NOT OK");
    $finish;
  end

endmodule
